// File: rtl/core/asd_pkg.sv
package asd_pkg;

  localparam int WARMUP_FRAMES_DEF = 16;
  localparam int NUM_REGS = 8;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_DEB  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_WIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_COS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_HOLD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_DEB   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_ALPHA = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ALPHA = 3'd7;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAG_LD,   // load sum of squares into sqrt unit
    ST_MAG_RUN,
    ST_WARM,     // warm-up divide per axis
    ST_WARM_RUN,
    ST_WARM_WB,
    ST_GEMA,     // gravity EMA per axis
    ST_SHAKE,
    ST_PREP,     // shifted vectors, sums
    ST_SQ_G,
    ST_SQ_G_RUN,
    ST_SQ_B,
    ST_SQ_B_RUN,
    ST_MULT,
    ST_DIV,
    ST_DIV_RUN,
    ST_TILT,
    ST_BEMA,
    ST_OUT
  } asd_state_t;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SQ_MAG,
    OP_WARM_DIV,
    OP_WARM_WB,
    OP_COPY_BASE,
    OP_GEMA,
    OP_SHAKE,
    OP_PREP,
    OP_SQ_G,
    OP_SQ_B,
    OP_MULT,
    OP_COS_DIV,
    OP_TILT,
    OP_BEMA,
    OP_PUBLISH
  } asd_op_t;

  typedef struct packed {
    asd_op_t    op;
    logic [1:0] axis;
    logic       unit_start;
  } asd_cmd_t;

  typedef struct packed {
    logic unit_busy;
    logic gravity_ready;
    logic warm_active;  // still averaging
    logic big_vecs;     // both vectors longer than 0.1 g
    logic rest_band;    // baseline may adapt
    logic tilted;
  } asd_stat_t;

endpackage

// File: rtl/core/asd_iter_unit.sv
// Shared iterative unit: integer square root (2 bits a step) or signed
// division truncated toward zero (1 bit a step).
module asd_iter_unit import asd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_div,
  input  logic [63:0] opa,   // radicand, or dividend magnitude
  input  logic [63:0] opb,   // divisor magnitude
  input  logic        neg,   // quotient sign
  output logic        busy,
  output logic [63:0] result
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] acc_r, acc_nxt;   // root or quotient
  logic [63:0] num_r, num_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        div_r, div_nxt;
  logic        neg_r, neg_nxt;
  logic        busy_r, busy_nxt;
  logic [65:0] trial;
  logic [64:0] shrem;

  always_comb begin
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    trial    = '0;
    shrem    = '0;
    if (start) begin
      busy_nxt = 1'b1;
      div_nxt  = is_div;
      neg_nxt  = neg;
      num_nxt  = opa;
      den_nxt  = opb;
      rem_nxt  = '0;
      acc_nxt  = '0;
      cnt_nxt  = is_div ? 7'd64 : 7'd32;
    end else if (busy_r) begin
      if (div_r) begin
        shrem = {rem_r, num_r[63]};
        num_nxt = {num_r[62:0], 1'b0};
        if (shrem >= {1'b0, den_r}) begin
          rem_nxt = 64'(shrem - {1'b0, den_r});
          acc_nxt = {acc_r[62:0], 1'b1};
        end else begin
          rem_nxt = shrem[63:0];
          acc_nxt = {acc_r[62:0], 1'b0};
        end
      end else begin
        // restoring root: bring down two bits
        trial = {rem_r[63:0], num_r[63:62]} - {acc_r[63:0], 2'b01};
        num_nxt = {num_r[61:0], 2'b00};
        if (!trial[65] && ({rem_r, num_r[63:62]} >= {acc_r, 2'b01})) begin
          rem_nxt = trial[63:0];
          acc_nxt = {acc_r[62:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[61:0], num_r[63:62]};
          acc_nxt = {acc_r[62:0], 1'b0};
        end
      end
      cnt_nxt = 7'(cnt_r - 7'd1);
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign busy   = busy_r;
  assign result = (div_r && neg_r) ? 64'(-acc_r) : acc_r;

endmodule

// File: rtl/core/asd_ctrl.sv
module asd_ctrl import asd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  asd_stat_t stat,
  output asd_cmd_t  cmd
);

  asd_state_t state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       ov_r, ov_nxt;
  logic       last_axis;

  assign last_axis = (axis_r == 2'd2);
  assign in_stall  = !(state_r == ST_IDLE && (!ov_r || !out_stall));
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    ov_nxt    = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE:     if (in_valid && !in_stall) state_nxt = ST_MAG_LD;
      ST_MAG_LD:   state_nxt = ST_MAG_RUN;
      ST_MAG_RUN:  if (!stat.unit_busy) begin
        axis_nxt = 2'd0;
        if (!stat.gravity_ready) state_nxt = stat.warm_active ? ST_WARM : ST_SHAKE;
        else state_nxt = ST_GEMA;
      end
      ST_WARM:     state_nxt = ST_WARM_RUN;
      ST_WARM_RUN: if (!stat.unit_busy) state_nxt = ST_WARM_WB;
      ST_WARM_WB:  begin
        if (last_axis) state_nxt = ST_SHAKE;
        else begin
          axis_nxt  = 2'(axis_r + 2'd1);
          state_nxt = ST_WARM;
        end
      end
      ST_GEMA:     begin
        if (last_axis) state_nxt = ST_SHAKE;
        else axis_nxt = 2'(axis_r + 2'd1);
      end
      ST_SHAKE:    state_nxt = stat.gravity_ready ? ST_PREP : ST_OUT;
      ST_PREP:     state_nxt = ST_SQ_G;
      // short vectors skip the cosine
      ST_SQ_G:     state_nxt = stat.big_vecs ? ST_SQ_G_RUN : ST_TILT;
      ST_SQ_G_RUN: if (!stat.unit_busy) state_nxt = ST_SQ_B;
      ST_SQ_B:     state_nxt = ST_SQ_B_RUN;
      ST_SQ_B_RUN: if (!stat.unit_busy) state_nxt = ST_MULT;
      ST_MULT:     state_nxt = ST_DIV;
      ST_DIV:      state_nxt = ST_DIV_RUN;
      ST_DIV_RUN:  if (!stat.unit_busy) state_nxt = ST_TILT;
      ST_TILT:     begin
        axis_nxt  = 2'd0;
        state_nxt = (!stat.tilted && stat.rest_band) ? ST_BEMA : ST_OUT;
      end
      ST_BEMA:     begin
        if (last_axis) state_nxt = ST_OUT;
        else axis_nxt = 2'(axis_r + 2'd1);
      end
      ST_OUT:      begin
        ov_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op         = OP_NONE;
    cmd.axis       = axis_r;
    cmd.unit_start = 1'b0;
    case (state_r)
      ST_IDLE:     if (in_valid && !in_stall) cmd.op = OP_CAPTURE;
      ST_MAG_LD:   begin cmd.op = OP_SQ_MAG; cmd.unit_start = 1'b1; end
      ST_MAG_RUN:  if (!stat.unit_busy && !stat.gravity_ready && !stat.warm_active)
                     cmd.op = OP_COPY_BASE;
      ST_WARM:     begin cmd.op = OP_WARM_DIV; cmd.unit_start = 1'b1; end
      ST_WARM_WB:  cmd.op = OP_WARM_WB;
      ST_GEMA:     cmd.op = OP_GEMA;
      ST_SHAKE:    cmd.op = OP_SHAKE;
      ST_PREP:     cmd.op = OP_PREP;
      ST_SQ_G:     begin cmd.op = OP_SQ_G; cmd.unit_start = stat.big_vecs; end
      ST_SQ_B:     begin cmd.op = OP_SQ_B; cmd.unit_start = 1'b1; end
      ST_MULT:     cmd.op = OP_MULT;
      ST_DIV:      begin cmd.op = OP_COS_DIV; cmd.unit_start = 1'b1; end
      ST_TILT:     cmd.op = OP_TILT;
      ST_BEMA:     cmd.op = OP_BEMA;
      ST_OUT:      cmd.op = OP_PUBLISH;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// File: rtl/core/asd_dp.sv
module asd_dp import asd_pkg::*; #(
  parameter int WARMUP_FRAMES = WARMUP_FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic signed [15:0]   in_accel_x,
  input  logic signed [15:0]   in_accel_y,
  input  logic signed [15:0]   in_accel_z,
  input  logic [31:0]          in_time_ms,
  input  asd_cmd_t             cmd,
  output asd_stat_t            stat,
  output logic                 out_shake_event,
  output logic                 out_pickup_event,
  output logic [7:0]           out_shakes_in_window,
  output logic [15:0]          out_magnitude,
  output logic                 out_baseline_ready
);

  // config
  logic [15:0] shake_thr_r, shake_deb_r, shake_win_r, tilt_hold_r, tilt_deb_r;
  logic [15:0] grav_alpha_r, base_alpha_r;
  logic signed [15:0] tilt_cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shake_thr_r  <= 16'd32768;
      shake_deb_r  <= 16'd200;
      shake_win_r  <= 16'd1000;
      tilt_cos_r   <= 16'sd23170;
      tilt_hold_r  <= 16'd500;
      tilt_deb_r   <= 16'd2000;
      grav_alpha_r <= 16'd6554;
      base_alpha_r <= 16'd66;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHAKE_THR:  shake_thr_r  <= cfg_data;
        REG_SHAKE_DEB:  shake_deb_r  <= cfg_data;
        REG_SHAKE_WIN:  shake_win_r  <= cfg_data;
        REG_TILT_COS:   tilt_cos_r   <= cfg_data;
        REG_TILT_HOLD:  tilt_hold_r  <= cfg_data;
        REG_TILT_DEB:   tilt_deb_r   <= cfg_data;
        REG_GRAV_ALPHA: grav_alpha_r <= cfg_data;
        REG_BASE_ALPHA: base_alpha_r <= cfg_data;
        default: ;
      endcase
    end
  end

  localparam int WC_W = 9;

  logic signed [15:0] s_r [3];
  logic [31:0] now_r;
  logic [34:0] sum_r;
  logic [15:0] mag_r;
  logic signed [31:0] grav_r [3];
  logic signed [31:0] base_r [3];
  logic [WC_W-1:0] wc_r;
  logic gready_r;
  logic [31:0] last_shake_r, win_start_r, tilt_start_r, last_pick_r;
  logic [7:0] cnt_r;
  logic in_zone_r;
  logic shake_ev_r, pick_ev_r;
  logic signed [23:0] gs_r [3];
  logic signed [23:0] bs_r [3];
  logic signed [23:0] gs_w [3];
  logic signed [23:0] bs_w [3];
  logic [48:0] sg_r, sb_r;
  logic signed [49:0] dot_r;
  logic [24:0] mg_r;
  logic [49:0] prod_r;
  logic big_r;
  logic signed [17:0] cos_r;
  logic [15:0] o_mag_r;
  logic [7:0] o_cnt_r;
  logic o_sh_r, o_pk_r, o_rdy_r;

  // iterative unit
  logic        u_start, u_div, u_neg, u_busy;
  logic [63:0] u_a, u_b, u_res;

  asd_iter_unit u_iter (
    .clk(clk), .rst_n(rst_n), .start(u_start), .is_div(u_div),
    .opa(u_a), .opb(u_b), .neg(u_neg), .busy(u_busy), .result(u_res)
  );

  logic signed [47:0] warm_d;
  logic signed [31:0] gsel, bsel;
  logic signed [32:0] dg, db;
  logic signed [49:0] pg, pb;
  logic signed [63:0] cosnum;
  logic signed [64:0] dg_w;

  assign gsel = grav_r[cmd.axis];
  assign bsel = base_r[cmd.axis];
  assign warm_d = 48'(48'(s_r[cmd.axis]) <<< 15) - 48'(gsel);
  assign dg = (33'(s_r[cmd.axis]) <<< 15) - 33'(gsel);
  assign db = 33'(gsel) - 33'(bsel);
  assign pg = 50'(dg) * $signed({1'b0, grav_alpha_r});
  assign pb = 50'(db) * $signed({1'b0, base_alpha_r});
  assign cosnum = 64'(dot_r) <<< 15;
  assign dg_w = 65'(cosnum);

  // floor-shifted vectors for the cosine
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gs_w[i] = 24'(grav_r[i] >>> 8);
      bs_w[i] = 24'(base_r[i] >>> 8);
    end
  end

  always_comb begin
    u_start = cmd.unit_start;
    u_div   = 1'b0;
    u_neg   = 1'b0;
    u_a     = '0;
    u_b     = '1;
    case (cmd.op)
      OP_SQ_MAG: u_a = 64'(sum_r);
      OP_WARM_DIV: begin
        u_div = 1'b1;
        u_neg = warm_d[47];
        u_a   = warm_d[47] ? 64'(-warm_d) : 64'(warm_d);
        u_b   = 64'(wc_r) + 64'd1;
      end
      OP_SQ_G: u_a = 64'(sg_r);
      OP_SQ_B: u_a = 64'(sb_r);
      OP_COS_DIV: begin
        u_div = 1'b1;
        u_neg = dot_r[49];
        u_a   = dot_r[49] ? 64'(-dg_w) : 64'(dg_w);
        u_b   = 64'(prod_r);
      end
      default: ;
    endcase
  end

  logic [31:0] e_shake, e_win, e_tilt, e_pick;
  assign e_shake = now_r - last_shake_r;
  assign e_win   = now_r - win_start_r;
  assign e_tilt  = now_r - tilt_start_r;
  assign e_pick  = now_r - last_pick_r;

  logic [39:0] sum25;
  logic [54:0] sg25, sb25;
  logic shake_hit, tilt_now;
  assign sum25 = 40'(sum_r) * 40'd25;
  assign sg25  = 55'(sg_r) * 55'd25;
  assign sb25  = 55'(sb_r) * 55'd25;
  assign shake_hit = (mag_r > shake_thr_r) && (e_shake >= 32'(shake_deb_r));
  assign tilt_now  = big_r && ($signed(cos_r) < $signed(18'(tilt_cos_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        grav_r[i] <= '0;
        base_r[i] <= '0;
      end
      wc_r <= '0;
      gready_r <= 1'b0;
      last_shake_r <= '0;
      win_start_r <= '0;
      cnt_r <= '0;
      in_zone_r <= 1'b0;
      tilt_start_r <= '0;
      last_pick_r <= '0;
      o_sh_r <= 1'b0;
      o_pk_r <= 1'b0;
      o_cnt_r <= '0;
      o_rdy_r <= 1'b0;
      o_mag_r <= '0;
    end else begin
      case (cmd.op)
        OP_CAPTURE: begin
          s_r[0] <= in_accel_x;
          s_r[1] <= in_accel_y;
          s_r[2] <= in_accel_z;
          now_r  <= in_time_ms;
          sum_r  <= 35'(in_accel_x * in_accel_x) + 35'(in_accel_y * in_accel_y)
                  + 35'(in_accel_z * in_accel_z);
          shake_ev_r <= 1'b0;
          pick_ev_r  <= 1'b0;
        end
        OP_WARM_WB: begin
          grav_r[cmd.axis] <= 32'(gsel + u_res[31:0]);
          if (cmd.axis == 2'd2) wc_r <= WC_W'(wc_r + 1'b1);
        end
        OP_COPY_BASE: begin
          for (int i = 0; i < 3; i++) base_r[i] <= grav_r[i];
          gready_r <= 1'b1;
        end
        OP_GEMA: grav_r[cmd.axis] <= 32'(gsel + 32'(pg >>> 16));
        OP_SHAKE: begin
          if (shake_hit) begin
            last_shake_r <= now_r;
            shake_ev_r <= 1'b1;
            if (cnt_r == 8'd0 || e_win > 32'(shake_win_r)) begin
              win_start_r <= now_r;
              cnt_r <= 8'd1;
            end else if (cnt_r != 8'd255) cnt_r <= 8'(cnt_r + 1'b1);
          end else if (cnt_r != 8'd0 && e_win > 32'(shake_win_r))
            cnt_r <= 8'd0;
        end
        OP_PREP: begin
          for (int i = 0; i < 3; i++) begin
            gs_r[i] <= gs_w[i];
            bs_r[i] <= bs_w[i];
          end
          sg_r  <= 49'(gs_w[0]*gs_w[0]) + 49'(gs_w[1]*gs_w[1]) + 49'(gs_w[2]*gs_w[2]);
          sb_r  <= 49'(bs_w[0]*bs_w[0]) + 49'(bs_w[1]*bs_w[1]) + 49'(bs_w[2]*bs_w[2]);
        end
        OP_SQ_G: begin
          dot_r <= 50'(gs_r[0]*bs_r[0]) + 50'(gs_r[1]*bs_r[1]) + 50'(gs_r[2]*bs_r[2]);
        end
        OP_SQ_B: mg_r <= u_res[24:0];
        OP_MULT: prod_r <= 50'(mg_r) * 50'(u_res[24:0]);
        OP_TILT: begin
          if (tilt_now) begin
            if (!in_zone_r) begin
              in_zone_r <= 1'b1;
              tilt_start_r <= now_r;
            end
            if ((in_zone_r ? e_tilt : 32'd0) >= 32'(tilt_hold_r) &&
                e_pick >= 32'(tilt_deb_r)) begin
              last_pick_r <= now_r;
              pick_ev_r <= 1'b1;
            end
          end else begin
            in_zone_r <= 1'b0;
            tilt_start_r <= '0;
          end
        end
        OP_BEMA: base_r[cmd.axis] <= 32'(bsel + 32'(pb >>> 16));
        OP_PUBLISH: begin
          o_sh_r  <= shake_ev_r;
          o_pk_r  <= pick_ev_r;
          o_cnt_r <= cnt_r;
          o_mag_r <= mag_r;
          o_rdy_r <= gready_r;
        end
        default: ;
      endcase
    end
  end

  // take the magnitude and the cosine when the unit finishes
  logic cos_take_r, mag_take_r;
  logic signed [64:0] cq;
  assign cq = $signed(u_res);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_take_r <= 1'b0;
      mag_take_r <= 1'b0;
      big_r      <= 1'b0;
      cos_r      <= 18'sd32768;
      mag_r      <= '0;
    end else begin
      cos_take_r <= (cmd.op == OP_COS_DIV) || (cos_take_r && u_busy);
      mag_take_r <= (cmd.op == OP_SQ_MAG) || (mag_take_r && u_busy);
      if (cmd.op == OP_CAPTURE) begin
        big_r <= 1'b0;
        cos_r <= 18'sd32768;
      end
      if (cmd.op == OP_SQ_G) big_r <= stat.big_vecs;
      if (cos_take_r && !u_busy) begin
        if (cq > 65'sd32768) cos_r <= 18'sd32768;
        else if (cq < -65'sd32768) cos_r <= -18'sd32768;
        else cos_r <= 18'(cq);
      end
      if (mag_take_r && !u_busy) begin
        if (u_res > 64'd65535) mag_r <= 16'hFFFF;
        else mag_r <= u_res[15:0];
      end
    end
  end

  assign stat.unit_busy     = u_busy;
  assign stat.gravity_ready = gready_r;
  assign stat.warm_active   = (32'(wc_r) < 32'(WARMUP_FRAMES));
  assign stat.big_vecs      = (sg25 > (55'(1) << 40)) && (sb25 > (55'(1) << 40));
  assign stat.rest_band     = (sum25 > 40'd4848615424) && (sum25 < 40'd8875147264);
  assign stat.tilted        = tilt_now;

  assign out_shake_event      = o_sh_r;
  assign out_pickup_event     = o_pk_r;
  assign out_shakes_in_window = o_cnt_r;
  assign out_magnitude        = o_mag_r;
  assign out_baseline_ready   = o_rdy_r;

endmodule

// File: rtl/core/accel_shake_and_tilt_detector_unit.sv
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | accel_x, accel_y, accel_z, time_ms
// out     | output    | out_valid/out_stall | events, count, magnitude, ready
// cfg     | input     | cfg_we            | cfg_index, cfg_data
// A sample is taken only once the previous one is through; the time per
// sample is set by the shared root/divide unit (32 steps a root, 64 a
// divide), and is less when a vector is too short for the cosine.
// Reset is synchronous, active low; state resets, scratch registers do not.
// A held result does not block the next sample once the output is taken.
module accel_shake_and_tilt_detector_unit import asd_pkg::*; #(
  parameter int WARMUP_FRAMES = WARMUP_FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   in_accel_x,
  input  logic signed [15:0]   in_accel_y,
  input  logic signed [15:0]   in_accel_z,
  input  logic [31:0]          in_time_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_shake_event,
  output logic                 out_pickup_event,
  output logic [7:0]           out_shakes_in_window,
  output logic [15:0]          out_magnitude,
  output logic                 out_baseline_ready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  asd_cmd_t  cmd;
  asd_stat_t stat;

  asd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  asd_dp #(.WARMUP_FRAMES(WARMUP_FRAMES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_accel_x(in_accel_x), .in_accel_y(in_accel_y),
    .in_accel_z(in_accel_z), .in_time_ms(in_time_ms), .cmd(cmd), .stat(stat),
    .out_shake_event(out_shake_event), .out_pickup_event(out_pickup_event),
    .out_shakes_in_window(out_shakes_in_window), .out_magnitude(out_magnitude),
    .out_baseline_ready(out_baseline_ready)
  );

endmodule

// File: rtl/core/asd_checker.sv
module asd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_baseline_ready,
  input logic out_pickup_event
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second sample taken");
  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_baseline_ready |=> out_baseline_ready)
    else $error("baseline ready fell");
  a_pick_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pickup_event |-> out_baseline_ready)
    else $error("pickup before warm-up");

endmodule

bind accel_shake_and_tilt_detector_unit asd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_baseline_ready(out_baseline_ready), .out_pickup_event(out_pickup_event)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench import asd_pkg::*;;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [31:0]        tms;
  } sample_t;

  typedef struct {
    logic        shake;
    logic        pickup;
    logic [7:0]  count;
    logic [15:0] mag;
    logic        ready;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic [31:0] in_time_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_shake_event;
  logic out_pickup_event;
  logic [7:0] out_shakes_in_window;
  logic [15:0] out_magnitude;
  logic out_baseline_ready;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  accel_shake_and_tilt_detector_unit uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state and register copies
  longint unsigned thr, sdeb, swin, thold, tdeb, galpha, balpha;
  longint tcos;
  longint grav[3], base[3];
  int unsigned warm_n;
  bit grav_rdy;
  logic [31:0] last_shake, win_start, tilt_start, last_pick;
  int unsigned shake_cnt;
  bit tilt_zone;

  sample_t  pending_samples[$];
  verdict_t expected_verdicts[$];
  int  mismatches = 0;
  bit  timed_out = 0;
  bit  quiet = 0;        // no idling in the closing stretch
  bit  hold_req = 0;     // long receiver stall request
  bit  hold_done = 0;
  bit  took = 0;         // current beat accepted at the last rising edge
  int  idle_left = 0;
  int  sent = 0;
  longint cycles = 0;

  function automatic longint fshift(longint x, int k);
    return x >>> k;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r = 0, b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint blend(longint v, longint tgt, longint unsigned a);
    longint d = tgt - v;
    longint r = v + fshift(d * longint'(a), 16);
    return longint'(int'(r));
  endfunction

  task automatic reset_model();
    thr = 32768; sdeb = 200; swin = 1000; tcos = 23170;
    thold = 500; tdeb = 2000; galpha = 6554; balpha = 66;
    for (int i = 0; i < 3; i++) begin
      grav[i] = 0;
      base[i] = 0;
    end
    warm_n = 0; grav_rdy = 0; last_shake = 0; win_start = 0; shake_cnt = 0;
    tilt_zone = 0; tilt_start = 0; last_pick = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SHAKE_THR:  thr = val;
      REG_SHAKE_DEB:  sdeb = val;
      REG_SHAKE_WIN:  swin = val;
      REG_TILT_COS:   tcos = longint'($signed(val));
      REG_TILT_HOLD:  thold = val;
      REG_TILT_DEB:   tdeb = val;
      REG_GRAV_ALPHA: galpha = val;
      default:        balpha = val;
    endcase
  endtask

  function automatic verdict_t predict_events(sample_t sm);
    verdict_t v;
    longint sv[3];
    longint unsigned sum = 0, mag;
    logic [31:0] now = sm.tms;
    longint g[3], b[3], dot, cosq, prod;
    longint unsigned sg, sb;
    sv[0] = sm.ax; sv[1] = sm.ay; sv[2] = sm.az;
    v.shake = 0; v.pickup = 0;
    for (int i = 0; i < 3; i++) sum += longint'(sv[i] * sv[i]);
    mag = root64(sum);
    if (mag > 65535) mag = 65535;
    if (!grav_rdy) begin
      if (warm_n < WARMUP_FRAMES_DEF) begin
        for (int i = 0; i < 3; i++)
          grav[i] = longint'(int'(grav[i] + (sv[i] * 32768 - grav[i]) / longint'(warm_n + 1)));
        warm_n++;
      end else begin
        for (int i = 0; i < 3; i++) base[i] = grav[i];
        grav_rdy = 1;
      end
    end else
      for (int i = 0; i < 3; i++) grav[i] = blend(grav[i], sv[i] * 32768, galpha);
    if (mag > thr && longint'(32'(now - last_shake)) >= sdeb) begin
      last_shake = now;
      if (shake_cnt == 0 || longint'(32'(now - win_start)) > swin) begin
        win_start = now;
        shake_cnt = 1;
      end else if (shake_cnt < 255) shake_cnt++;
      v.shake = 1;
    end
    if (shake_cnt > 0 && longint'(32'(now - win_start)) > swin) shake_cnt = 0;
    if (grav_rdy) begin
      dot = 0; sg = 0; sb = 0; cosq = 32768;
      for (int i = 0; i < 3; i++) begin
        g[i] = fshift(grav[i], 8);
        b[i] = fshift(base[i], 8);
        sg += g[i] * g[i];
        sb += b[i] * b[i];
        dot += g[i] * b[i];
      end
      if (sg * 25 > (64'd1 << 40) && sb * 25 > (64'd1 << 40)) begin
        prod = longint'(root64(sg) * root64(sb));
        cosq = (dot * 32768) / prod;
        if (cosq > 32768) cosq = 32768;
        if (cosq < -32768) cosq = -32768;
      end
      if (cosq < tcos) begin
        if (!tilt_zone) begin
          tilt_zone = 1;
          tilt_start = now;
        end
        if (longint'(32'(now - tilt_start)) >= thold &&
            longint'(32'(now - last_pick)) >= tdeb) begin
          last_pick = now;
          v.pickup = 1;
        end
      end else begin
        tilt_zone = 0;
        tilt_start = 0;
        if (sum * 25 > 64'd69632 * 64'd69632 && sum * 25 < 64'd94208 * 64'd94208)
          for (int i = 0; i < 3; i++) base[i] = blend(base[i], grav[i], balpha);
      end
    end
    v.count = shake_cnt[7:0];
    v.mag = mag[15:0];
    v.ready = grav_rdy;
    return v;
  endfunction

  // driver: present a new beat once the previous one was taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      took = 1'b0;
      if (quiet) idle_left = 0;
      if (pending_samples.size() > 0 && idle_left == 0 &&
          (quiet || $urandom_range(0, 5) != 0)) begin
        in_valid <= 1'b1;
        in_accel_x <= pending_samples[0].ax;
        in_accel_y <= pending_samples[0].ay;
        in_accel_z <= pending_samples[0].az;
        in_time_ms <= pending_samples[0].tms;
      end else begin
        in_valid <= 1'b0;
        if (idle_left > 0) idle_left--;
        else if (pending_samples.size() > 0) idle_left = $urandom_range(0, 6);
      end
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    sample_t s;
    if (rst_n && in_valid && !in_stall) begin
      s.ax = in_accel_x; s.ay = in_accel_y; s.az = in_accel_z; s.tms = in_time_ms;
      expected_verdicts.push_back(predict_events(s));
      void'(pending_samples.pop_front());
      sent++;
      took = 1'b1;
    end
  end

  // receiver stall: random bursts plus the long hold-off
  int stall_left = 0;
  int hold_cycles = 0;
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_cycles++;
      if (hold_cycles >= 2000) hold_done = 1'b1;
    end else if (quiet) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    verdict_t e;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat");
      end else begin
        e = expected_verdicts.pop_front();
        if (e.shake !== out_shake_event || e.pickup !== out_pickup_event ||
            e.count !== out_shakes_in_window || e.mag !== out_magnitude ||
            e.ready !== out_baseline_ready) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp sh=%0d pk=%0d cnt=%0d mag=%0d rdy=%0d got %0d %0d %0d %0d %0d",
                     e.shake, e.pickup, e.count, e.mag, e.ready, out_shake_event,
                     out_pickup_event, out_shakes_in_window, out_magnitude, out_baseline_ready);
        end
      end
    end
  end

  logic [31:0] clock_ms = 0;

  task automatic add_sample(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, int unsigned step);
    sample_t s;
    clock_ms += step;
    s.ax = x; s.ay = y; s.az = z; s.tms = clock_ms;
    pending_samples.push_back(s);
  endtask

  // gentle motion around an orientation, with occasional spikes and flips
  task automatic add_motion(int n, int spike_pct, int flip_pct);
    int gx, gy, gz;
    gx = 0; gy = 0; gz = 16384;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < flip_pct) begin
        case ($urandom_range(0, 2))
          0: begin gx = 16384; gy = 0; gz = 0; end
          1: begin gx = 0; gy = -16384; gz = 0; end
          default: begin gx = 0; gy = 0; gz = ($urandom_range(0, 1) ? 16384 : -16384); end
        endcase
      end
      if ($urandom_range(0, 99) < spike_pct)
        add_sample(16'($urandom), 16'($urandom), 16'($urandom), $urandom_range(1, 120));
      else
        add_sample(16'(gx + $urandom_range(0, 1600) - 800), 16'(gy + $urandom_range(0, 1600) - 800),
                   16'(gz + $urandom_range(0, 1600) - 800), $urandom_range(5, 60));
    end
  endtask

  task automatic drain();
    int guard = 0;
    while ((pending_samples.size() > 0 || in_valid || expected_verdicts.size() > 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (250) @(posedge clk);
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, warm-up, wrap of time, tiny vectors
    add_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    add_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1);
    add_sample(0, 0, 0, 300);
    add_sample(16'sh7fff, 0, 0, 250);
    add_sample(-16'sd32768, 0, 0, 10);
    for (int i = 0; i < 14; i++) add_sample(0, 0, 16384, 20);
    add_sample(0, 0, 16384, 20);
    add_sample(16384, 0, 0, 20);
    add_sample(100, 100, 100, 600);
    clock_ms = 32'hFFFF_FFF0;
    add_sample(0, 16384, 0, 5);
    add_sample(0, 16384, 0, 700);
    add_sample(-16'sd32768, 16'sh7fff, 0, 30);
    drain();

    // several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_SHAKE_THR, 16'd20000); write_reg(REG_SHAKE_DEB, 16'd0);
          write_reg(REG_SHAKE_WIN, 16'd65535); write_reg(REG_TILT_COS, 16'h7fff);
          write_reg(REG_TILT_HOLD, 16'd0); write_reg(REG_TILT_DEB, 16'd0);
          write_reg(REG_GRAV_ALPHA, 16'hffff); write_reg(REG_BASE_ALPHA, 16'hffff);
        end
        1: begin
          write_reg(REG_SHAKE_THR, 16'd0); write_reg(REG_SHAKE_WIN, 16'd0);
          write_reg(REG_TILT_COS, 16'h8000); write_reg(REG_GRAV_ALPHA, 16'd0);
          write_reg(REG_BASE_ALPHA, 16'd0);
        end
        2: begin
          write_reg(REG_SHAKE_THR, 16'hffff); write_reg(REG_SHAKE_DEB, 16'hffff);
          write_reg(REG_TILT_HOLD, 16'hffff); write_reg(REG_TILT_DEB, 16'hffff);
          write_reg(REG_TILT_COS, 16'd0);
        end
        default: begin
          write_reg(REG_SHAKE_THR, 16'($urandom_range(16000, 40000)));
          write_reg(REG_SHAKE_DEB, 16'($urandom_range(0, 300)));
          write_reg(REG_SHAKE_WIN, 16'($urandom_range(100, 3000)));
          write_reg(REG_TILT_COS, 16'($urandom_range(0, 30000)));
          write_reg(REG_TILT_HOLD, 16'($urandom_range(0, 600)));
          write_reg(REG_TILT_DEB, 16'($urandom_range(0, 2500)));
          write_reg(REG_GRAV_ALPHA, 16'($urandom));
          write_reg(REG_BASE_ALPHA, 16'($urandom_range(0, 2000)));
        end
      endcase
      if (ph == 5) quiet = 1;
      if (ph == 2) hold_req = 1;
      add_motion(230, 15, 4);
      drain();
    end

    if (mismatches == 0 && !timed_out && pending_samples.size() == 0 &&
        expected_verdicts.size() == 0)
      $display("accel_shake_and_tilt_detector_unit verification clean");
    else
      $display("accel_shake_and_tilt_detector_unit verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      timed_out = 1;
      $display("accel_shake_and_tilt_detector_unit verification failed");
      $finish;
    end
  end

endmodule

// File: accel_shake_and_tilt_detector_unit.f
rtl/core/asd_pkg.sv
rtl/core/asd_iter_unit.sv
rtl/core/asd_ctrl.sv
rtl/core/asd_dp.sv
rtl/core/accel_shake_and_tilt_detector_unit.sv
rtl/core/asd_checker.sv
tb/testbench.sv
